// ----- sv/gbc_pkg.sv -----
// shared types, constants and helpers of the gyro bias calibrator
`default_nettype none

package gbc_pkg;

  // defaults for the top level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int CFG_W    = 16;
  localparam int SUM_W    = 32;
  localparam int ACC_W    = SUM_W + 2;
  localparam int OFF_W    = 24;
  localparam int PHASE_W  = 2;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 16'd1000;

  localparam logic [PHASE_W-1:0] PH_READY   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COLLECT = 2'd2;

  localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SUM_LO = -(ACC_W'(64'sd2147483648));

  // magnitude limits of the mean offsets
  localparam longint unsigned OFF_POS_MAX = 64'd8388607;
  localparam longint unsigned OFF_NEG_MAG = 64'd8388608;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] res;
    if (v > SUM_HI) begin
      res = SUM_HI[SUM_W-1:0];
    end else if (v < SUM_LO) begin
      res = SUM_LO[SUM_W-1:0];
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gbc_in_if.sv -----
// input channel of the gyro bias calibrator: one gyro sample beat
`default_nettype none

interface gbc_in_if #(
  parameter int SAMPLE_WIDTH = gbc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           start_request;
  logic                           device_still;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [SAMPLE_WIDTH-1:0] rate_z;

  modport source (
    output valid, start_request, device_still, rate_x, rate_y, rate_z,
    input  ready
  );

  modport sink (
    input  valid, start_request, device_still, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/gbc_out_if.sv -----
// result channel of the gyro bias calibrator: status and mean offsets
`default_nettype none

interface gbc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                updated;
  logic [gbc_pkg::PHASE_W-1:0]         phase;
  logic                                calibrating;
  logic                                done_res;
  logic signed [gbc_pkg::OFF_W-1:0]    offset_x;
  logic signed [gbc_pkg::OFF_W-1:0]    offset_y;
  logic signed [gbc_pkg::OFF_W-1:0]    offset_z;

  modport source (
    output valid, updated, phase, calibrating, done_res, offset_x, offset_y, offset_z,
    input  ready
  );

  modport sink (
    input  valid, updated, phase, calibrating, done_res, offset_x, offset_y, offset_z,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/gbc_div.sv -----
// radix-2 restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module gbc_div #(
  parameter int DW = 40,
  parameter int VW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DW-1:0]     dividend,
  input  wire logic [VW-1:0]     divisor,
  output gbc_pkg::div_stat_t     stat,
  output logic      [DW-1:0]     quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    quo_nxt;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    rem_nxt;
  logic [VW-1:0]    dvs_r;
  logic [VW:0]      trial;
  logic             fits;

  // shift the next dividend bit into the partial remainder
  assign trial   = {rem_r, quo_r[DW-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
  assign quo_nxt = {quo_r[DW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dvs_r)
    else $error("remainder not below divisor at end of division");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r && !busy_r)
    else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// ----- sv/gyro_bias_calibrator.sv -----
// gyro bias calibrator: averages still gyro samples into zero-rate offsets
//
// in_bus carries one three-axis gyro sample per beat with a start request and a
// stillness flag; out_bus returns one status and offset beat for every input beat.
// cfg_we/cfg_wdata load the sample count; the user must write it only while the
// block is idle, as the block itself does not enforce this. A beat that only
// moves the phase (ready, wait, motion) goes from the idle state through the
// output state into the output register. A still sample while collecting
// recomputes the three running means through one shared serial divider, one axis
// after another, through a start and a divide state per axis. in_bus.ready is
// high only while the sequencer is idle, so one beat is worked on at a time.
// A finished result sits in the output register; the next beat is accepted while
// it waits, and its own result holds back until out_bus.ready frees the register.
// Reset (rst_n low, synchronous) returns to the ready phase with zero sums and
// offsets, an empty output register and a sample count of 1000.
`default_nettype none

module gyro_bias_calibrator #(
  parameter int SAMPLE_WIDTH = gbc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = gbc_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS    = gbc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [gbc_pkg::CFG_W-1:0]   cfg_wdata,
  gbc_in_if.sink                           in_bus,
  gbc_out_if.source                        out_bus
);

  localparam int CW      = COUNT_WIDTH;
  localparam int SUM_W   = gbc_pkg::SUM_W;
  localparam int ACC_W   = gbc_pkg::ACC_W;
  localparam int OFF_W   = gbc_pkg::OFF_W;
  localparam int CFG_W   = gbc_pkg::CFG_W;
  localparam int AXIS_W  = gbc_pkg::AXIS_W;
  localparam int NAX     = gbc_pkg::NUM_AXES;
  localparam int DW      = SUM_W + FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } seq_state_t;

  seq_state_t                     state_r;
  logic [CFG_W-1:0]               cfg_count_r;
  logic [gbc_pkg::PHASE_W-1:0]    phase_r;
  logic                           busy_flag_r;
  logic [CW-1:0]                  left_r;
  logic [CW-1:0]                  n_r;
  logic [AXIS_W-1:0]              axis_r;
  logic signed [SUM_W-1:0]        sum_r  [NAX];
  logic signed [OFF_W-1:0]        mean_r [NAX];
  logic                           upd_r;
  logic                           done_pend_r;

  logic                           out_valid_r;
  logic                           out_updated_r;
  logic [gbc_pkg::PHASE_W-1:0]    out_phase_r;
  logic                           out_cal_r;
  logic                           out_done_r;
  logic signed [OFF_W-1:0]        out_off_r [NAX];

  logic                           in_fire;
  logic [CW+CFG_W-1:0]            count_ext;
  logic [CW-1:0]                  count_m;
  logic [CW-1:0]                  total;
  logic [CW-1:0]                  left_base;
  logic [CW-1:0]                  left_new;
  logic signed [SAMPLE_WIDTH-1:0] smp [NAX];
  logic signed [SUM_W-1:0]        sum_new [NAX];

  logic signed [SUM_W-1:0]        sum_sel;
  logic signed [DW-1:0]           prod;
  logic [DW-1:0]                  mag;
  logic                           neg;
  logic [DW-1:0]                  quo;
  logic signed [OFF_W-1:0]        mean_sat;
  gbc_pkg::div_stat_t             div_stat;
  logic                           div_start;
  logic                           out_load;

  assign in_fire = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);

  // sample count taken modulo 2^COUNT_WIDTH, zero treated as one
  assign count_ext = {{CW{1'b0}}, cfg_count_r};
  assign count_m   = count_ext[CW-1:0];
  assign total     = (count_m == '0) ? CW'(1) : count_m;
  assign left_base = (left_r == '0 || left_r > total) ? total : left_r;
  assign left_new  = left_base - 1'b1;

  assign smp[0] = in_bus.rate_x;
  assign smp[1] = in_bus.rate_y;
  assign smp[2] = in_bus.rate_z;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      sum_new[i] = gbc_pkg::sat_sum(ACC_W'(sum_r[i]) + ACC_W'(smp[i]));
    end
  end

  // divide |sum * 2^FRAC_BITS| by n, then restore the sign
  assign sum_sel = sum_r[axis_r];
  assign neg     = sum_sel[SUM_W-1];
  assign prod    = DW'(sum_sel) <<< FRAC_BITS;
  assign mag     = neg ? DW'(-prod) : DW'(prod);

  always_comb begin
    if (neg) begin
      if (quo > DW'(gbc_pkg::OFF_NEG_MAG)) begin
        mean_sat = OFF_W'(-(64'sd8388608));
      end else begin
        mean_sat = -($signed(quo[OFF_W-1:0]));
      end
    end else begin
      if (quo > DW'(gbc_pkg::OFF_POS_MAX)) begin
        mean_sat = OFF_W'(gbc_pkg::OFF_POS_MAX);
      end else begin
        mean_sat = $signed(quo[OFF_W-1:0]);
      end
    end
  end

  assign div_start = (state_r == ST_START);

  gbc_div #(
    .DW (DW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (n_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= gbc_pkg::CFG_COUNT_RESET;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= gbc_pkg::PH_READY;
      busy_flag_r <= 1'b0;
      left_r      <= '0;
      n_r         <= CW'(1);
      axis_r      <= '0;
      upd_r       <= 1'b0;
      done_pend_r <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        sum_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            upd_r       <= 1'b1;
            done_pend_r <= 1'b0;
            state_r     <= ST_OUT;
            case (phase_r)
              gbc_pkg::PH_WAIT: begin
                busy_flag_r <= 1'b1;
                left_r      <= total;
                phase_r     <= gbc_pkg::PH_COLLECT;
                for (int i = 0; i < NAX; i++) begin
                  sum_r[i]  <= '0;
                  mean_r[i] <= '0;
                end
              end
              gbc_pkg::PH_COLLECT: begin
                if (in_bus.device_still) begin
                  left_r  <= left_new;
                  n_r     <= total - left_new;
                  axis_r  <= '0;
                  state_r <= ST_START;
                  for (int i = 0; i < NAX; i++) begin
                    sum_r[i] <= sum_new[i];
                  end
                  if (left_new == '0) begin
                    done_pend_r <= 1'b1;
                    busy_flag_r <= 1'b0;
                    phase_r     <= gbc_pkg::PH_READY;
                  end
                end else begin
                  phase_r <= gbc_pkg::PH_WAIT;
                end
              end
              default: begin
                // unused phase code behaves as ready
                if (in_bus.start_request) begin
                  phase_r <= gbc_pkg::PH_WAIT;
                end else begin
                  phase_r <= gbc_pkg::PH_READY;
                  upd_r   <= 1'b0;
                end
              end
            endcase
          end
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            mean_r[axis_r] <= mean_sat;
            if (axis_r == AXIS_W'(NAX - 1)) begin
              state_r <= ST_OUT;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= ST_START;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_updated_r <= upd_r;
      out_phase_r   <= phase_r;
      out_cal_r     <= busy_flag_r;
      out_done_r    <= done_pend_r;
      for (int i = 0; i < NAX; i++) begin
        out_off_r[i] <= mean_r[i];
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.updated     = out_updated_r;
  assign out_bus.phase       = out_phase_r;
  assign out_bus.calibrating = out_cal_r;
  assign out_bus.done_res    = out_done_r;
  assign out_bus.offset_x    = out_off_r[0];
  assign out_bus.offset_y    = out_off_r[1];
  assign out_bus.offset_z    = out_off_r[2];

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while still busy");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> n_r != '0 && n_r <= total)
    else $error("sample divisor out of range");

  a_done_leaves_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_phase_r == gbc_pkg::PH_READY && !out_cal_r)
    else $error("done beat without return to ready");

  a_no_accept_while_working: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !in_bus.ready && div_stat.busy || div_stat.done)
    else $error("sequencer waiting on an idle divider");

endmodule

`default_nettype wire
